// File: sv/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Operation and status codes, the default depth and controller/datapath structs.
// Depends on nothing.
`default_nettype none

package deq_pkg;

  localparam int unsigned DepthDef = 64;

  // Operation codes on func
  localparam logic [1:0] FN_PUSH_FRONT = 2'd0;
  localparam logic [1:0] FN_PUSH_BACK  = 2'd1;
  localparam logic [1:0] FN_POP_FRONT  = 2'd2;
  localparam logic [1:0] FN_POP_BACK   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch_in;  // capture input beat
    logic exec;      // apply operation, issue storage read
    logic load_rd;   // refresh cached end value from read data
    logic load_out;  // load result register
  } deq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic needs_read;  // pop leaves a new end value to fetch
  } deq_stat_t;

endpackage

`default_nettype wire

// File: sv/deq_datapath.sv
// Datapath of the double-ended queue: ring storage, pointers, cached ends, result.
// Driven by deq_ctrl through deq_cmd_t; uses deq_pkg.
`default_nettype none

module deq_datapath import deq_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  deq_cmd_t           cmd_i,
  output       deq_stat_t          stat_o,
  input  wire  logic [1:0]         func_i,
  input  wire  logic signed [31:0] value_i,
  output       logic [1:0]         status_o,
  output       logic signed [31:0] popped_value_o,
  output       logic signed [31:0] front_value_o,
  output       logic signed [31:0] back_value_o,
  output       logic [6:0]         entry_count_o,
  output       logic               is_empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 2;

  logic [31:0]       mem [DEPTH];

  logic [AW-1:0]     front_idx_q, front_idx_d;
  logic [CW-1:0]     count_q, count_d;
  logic [1:0]        func_q;
  logic signed [31:0] value_q;
  logic signed [31:0] front_val_q, back_val_q;
  logic [31:0]       rd_data_q;
  logic [1:0]        status_q;
  logic signed [31:0] popped_q;

  logic              empty, full;
  logic [SW-1:0]     f_ext, c_ext;
  logic [AW-1:0]     front_m1, front_p1, back_next, back_prev;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              mem_we;
  logic [CW+6:0]     count_wide;

  // Sum below twice the depth: one compare and subtract
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
    return r[AW-1:0];
  endfunction

  assign empty = (count_q == '0);
  assign full  = (count_q == CW'(DEPTH));
  assign f_ext = {{(SW-AW){1'b0}}, front_idx_q};
  assign c_ext = {{(SW-CW){1'b0}}, count_q};

  assign front_m1  = (front_idx_q == '0) ? AW'(DEPTH - 1) : (front_idx_q - AW'(1));
  assign front_p1  = wrap(f_ext + SW'(1));
  assign back_next = wrap(f_ext + c_ext);
  assign back_prev = wrap(f_ext + c_ext - SW'(2));

  assign rd_addr = (func_q == FN_POP_FRONT) ? front_p1 : back_prev;
  assign wr_addr = (func_q == FN_PUSH_FRONT) ? front_m1 : back_next;
  assign mem_we  = cmd_i.exec && !full &&
                   ((func_q == FN_PUSH_FRONT) || (func_q == FN_PUSH_BACK));

  assign stat_o.needs_read = ((func_q == FN_POP_FRONT) || (func_q == FN_POP_BACK)) &&
                             (count_q > CW'(1));

  // Pointer and count update
  always_comb begin
    front_idx_d = front_idx_q;
    count_d     = count_q;
    if (cmd_i.exec) begin
      case (func_q)
        FN_PUSH_FRONT: begin
          if (!full) begin
            front_idx_d = front_m1;
            count_d     = count_q + CW'(1);
          end
        end
        FN_PUSH_BACK: begin
          if (!full) count_d = count_q + CW'(1);
        end
        FN_POP_FRONT: begin
          if (!empty) begin
            front_idx_d = front_p1;
            count_d     = count_q - CW'(1);
          end
        end
        FN_POP_BACK: begin
          if (!empty) count_d = count_q - CW'(1);
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_idx_q <= '0;
      count_q     <= '0;
    end else begin
      front_idx_q <= front_idx_d;
      count_q     <= count_d;
    end
  end

  // Storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= value_q;
    if (cmd_i.exec) rd_data_q <= mem[rd_addr];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q  <= func_i;
      value_q <= value_i;
    end
    if (cmd_i.exec) begin
      status_q <= ST_DONE;
      popped_q <= '0;
      case (func_q)
        FN_PUSH_FRONT: begin
          if (full) begin
            status_q <= ST_FULL;
          end else begin
            front_val_q <= value_q;
            if (empty) back_val_q <= value_q;
          end
        end
        FN_PUSH_BACK: begin
          if (full) begin
            status_q <= ST_FULL;
          end else begin
            back_val_q <= value_q;
            if (empty) front_val_q <= value_q;
          end
        end
        FN_POP_FRONT: begin
          if (empty) status_q <= ST_EMPTY;
          else       popped_q <= front_val_q;
        end
        FN_POP_BACK: begin
          if (empty) status_q <= ST_EMPTY;
          else       popped_q <= back_val_q;
        end
        default: begin
          status_q <= ST_DONE;
        end
      endcase
    end
    if (cmd_i.load_rd) begin
      if (func_q == FN_POP_FRONT) front_val_q <= signed'(rd_data_q);
      else                        back_val_q  <= signed'(rd_data_q);
    end
    if (cmd_i.load_out) begin
      status_o       <= status_q;
      popped_value_o <= popped_q;
      front_value_o  <= empty ? '0 : front_val_q;
      back_value_o   <= empty ? '0 : back_val_q;
      entry_count_o  <= count_wide[6:0];
      is_empty_o     <= empty;
    end
  end

  assign count_wide = {7'b0, count_q};

endmodule

`default_nettype wire

// File: sv/deq_ctrl.sv
// Controller of the double-ended queue: sequences one operation at a time.
// Owns both handshakes and the result valid flag; uses deq_pkg.
`default_nettype none

module deq_ctrl import deq_pkg::*; (
  input  wire  logic      clk_i,
  input  wire  logic      rst_ni,
  input  wire  logic      in_valid_i,
  output       logic      in_stall_o,
  output       logic      out_valid_o,
  input  wire  logic      out_stall_i,
  input  wire  deq_stat_t stat_i,
  output       deq_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  // Result register free, or its beat leaves this cycle
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.needs_read ? S_READ : S_DONE;
      end
      S_READ: begin
        cmd_o.load_rd = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.load_out)              out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/double_ended_queue.sv
// Double-ended queue of signed 32-bit values over a ring buffer of DEPTH entries.
// Top level: joins deq_ctrl and deq_datapath; uses deq_pkg.
//
// Usage notes
// - Input channel (in_valid_i / in_stall_o): one beat carries func_i and value_i.
//   func_i selects push front, push back, pop front or pop back; value_i is
//   ignored on pops. A beat is taken when in_valid_i is high and in_stall_o low.
// - Output channel (out_valid_o / out_stall_i): one result beat per input beat,
//   in order: status, popped value, front and back values, count, empty flag.
// - One operation is in flight at a time. A push or a failed pop goes through the
//   execute and load states before loading the result register; a pop that leaves
//   entries behind adds a read state between them, the registered read of the
//   storage read port that fetches the new front or back value.
// - A new input beat is taken only once the controller's execute / read / load
//   sequence for the last one has finished.
// - Front and back values are cached in registers, so only such pops use the data
//   from the storage read port.
// - A stalled result stays in its output register; the next input beat is still
//   taken and worked, and waits before loading until the result beat leaves.
// - Reset (rst_ni low, asynchronous) empties the queue and drops any pending
//   result. Storage is not cleared: only data from occupied entries is ever used.
`default_nettype none

module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               in_valid_i,
  output       logic               in_stall_o,
  input  wire  logic [1:0]         func_i,
  input  wire  logic signed [31:0] value_i,
  output       logic               out_valid_o,
  input  wire  logic               out_stall_i,
  output       logic [1:0]         status_o,
  output       logic signed [31:0] popped_value_o,
  output       logic signed [31:0] front_value_o,
  output       logic signed [31:0] back_value_o,
  output       logic [6:0]         entry_count_o,
  output       logic               is_empty_o
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  // Sequencing and handshakes
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage, pointers and result register
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (func_i),
    .value_i        (value_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o)
  );

endmodule

`default_nettype wire
